FILE: sv/ethtcp_pkg.sv
// ----------------------------------------------------------------------------
// ethtcp_pkg
// Types and constants shared by the Ethernet/IPv4/TCP header parser.
// ----------------------------------------------------------------------------
package ethtcp_pkg;

    localparam int POS_W = 16;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] MIN_HDR_BYTES  = 16'd20;

    // Result status, in the order the checks are made
    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_NOT_ETHERNET = 4'd1,
        ST_SHORT_FRAME  = 4'd2,
        ST_NOT_IPV4     = 4'd3,
        ST_SHORT_IP     = 4'd4,
        ST_TOTLEN_OVER  = 4'd5,
        ST_TOTLEN_UNDER = 4'd6,
        ST_IHL_UNDER    = 4'd7,
        ST_IHL_OVER     = 4'd8,
        ST_NOT_TCP      = 4'd9,
        ST_SHORT_SEG    = 4'd10,
        ST_BAD_OFFSET   = 4'd11
    } status_t;

    // Header fields of one frame, as captured at its last byte
    typedef struct packed {
        logic [POS_W-1:0] size;
        logic [15:0]      ether_kind;
        logic [15:0]      total_len;
        logic [3:0]       hdr_words;
        logic [7:0]       proto;
        logic [31:0]      src_addr;
        logic [31:0]      dst_addr;
        logic [15:0]      src_port;
        logic [15:0]      dst_port;
        logic [31:0]      seq_num;
        logic [31:0]      ack_num;
        logic [15:0]      offset_and_flags;
        logic [15:0]      window;
        logic [15:0]      tcp_checksum;
        logic [15:0]      urgent_ptr;
    } frame_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] offset_and_flags;
        logic [15:0] window;
        logic [15:0] tcp_checksum;
        logic [15:0] urgent_ptr;
        logic [15:0] payload_length;
    } result_t;

endpackage

FILE: sv/ethtcp_if.sv
// ----------------------------------------------------------------------------
// ethtcp_if
// Valid/ready channels of the parser: frame bytes in, header results out.
// ----------------------------------------------------------------------------
interface ethtcp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface ethtcp_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] offset_and_flags;
    logic [15:0] window;
    logic [15:0] tcp_checksum;
    logic [15:0] urgent_ptr;
    logic [15:0] payload_length;

    modport source (
        output valid, input ready,
        output status, output src_addr, output dst_addr, output src_port,
        output dst_port, output seq_num, output ack_num, output offset_and_flags,
        output window, output tcp_checksum, output urgent_ptr, output payload_length
    );
    modport sink (
        input valid, output ready,
        input status, input src_addr, input dst_addr, input src_port,
        input dst_port, input seq_num, input ack_num, input offset_and_flags,
        input window, input tcp_checksum, input urgent_ptr, input payload_length
    );
endinterface

FILE: sv/ethtcp_capture.sv
// ----------------------------------------------------------------------------
// ethtcp_capture
// Byte position counter and header field latches for the current frame.
// ----------------------------------------------------------------------------
module ethtcp_capture
    import ethtcp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 16384
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic [7:0] byte_data,
    input  logic       byte_last,
    output frame_t     frame_snap
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

    localparam logic [POS_W-1:0] POS_ETYPE_HI = 16'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO = 16'd13;
    localparam logic [POS_W-1:0] POS_IHL      = 16'd14;
    localparam logic [POS_W-1:0] POS_TLEN_HI  = 16'd16;
    localparam logic [POS_W-1:0] POS_TLEN_LO  = 16'd17;
    localparam logic [POS_W-1:0] POS_PROTO    = 16'd23;
    localparam logic [POS_W-1:0] POS_SRC_LO   = 16'd26;
    localparam logic [POS_W-1:0] POS_SRC_HI   = 16'd29;
    localparam logic [POS_W-1:0] POS_DST_LO   = 16'd30;
    localparam logic [POS_W-1:0] POS_DST_HI   = 16'd33;

    logic [POS_W-1:0] pos_reg;
    logic [15:0]      etype_reg;
    logic [15:0]      tlen_reg;
    logic [3:0]       words_reg;
    logic [7:0]       proto_reg;
    logic [31:0]      src_reg;
    logic [31:0]      dst_reg;
    logic [15:0]      sport_reg;
    logic [15:0]      dport_reg;
    logic [31:0]      seq_reg;
    logic [31:0]      ack_reg;
    logic [15:0]      offs_reg;
    logic [15:0]      win_reg;
    logic [15:0]      csum_reg;
    logic [15:0]      urg_reg;

    frame_t           upd;        // state with this byte folded in
    logic [6:0]       tcp_start;
    logic [POS_W-1:0] tcp_rel;
    logic             in_tcp;
    logic             take;

    assign tcp_start = 7'd14 + {1'b0, words_reg, 2'b00};
    assign tcp_rel   = pos_reg - {{(POS_W-7){1'b0}}, tcp_start};
    assign in_tcp    = (pos_reg > POS_IHL)
                    && (pos_reg >= {{(POS_W-7){1'b0}}, tcp_start})
                    && (tcp_rel < MIN_HDR_BYTES);
    assign take      = byte_en && (pos_reg < MAX_POS);

    always_comb
    begin
        upd.size             = pos_reg;
        upd.ether_kind       = etype_reg;
        upd.total_len        = tlen_reg;
        upd.hdr_words        = words_reg;
        upd.proto            = proto_reg;
        upd.src_addr         = src_reg;
        upd.dst_addr         = dst_reg;
        upd.src_port         = sport_reg;
        upd.dst_port         = dport_reg;
        upd.seq_num          = seq_reg;
        upd.ack_num          = ack_reg;
        upd.offset_and_flags = offs_reg;
        upd.window           = win_reg;
        upd.tcp_checksum     = csum_reg;
        upd.urgent_ptr       = urg_reg;
        if (take)
        begin
            upd.size = pos_reg + 1'b1;
            if (pos_reg == POS_ETYPE_HI || pos_reg == POS_ETYPE_LO)
                upd.ether_kind = {etype_reg[7:0], byte_data};
            if (pos_reg == POS_IHL)
                upd.hdr_words = byte_data[3:0];
            if (pos_reg == POS_TLEN_HI || pos_reg == POS_TLEN_LO)
                upd.total_len = {tlen_reg[7:0], byte_data};
            if (pos_reg == POS_PROTO)
                upd.proto = byte_data;
            if (pos_reg >= POS_SRC_LO && pos_reg <= POS_SRC_HI)
                upd.src_addr = {src_reg[23:0], byte_data};
            if (pos_reg >= POS_DST_LO && pos_reg <= POS_DST_HI)
                upd.dst_addr = {dst_reg[23:0], byte_data};
            // TCP header, 20 bytes from 14 + IHL*4
            if (in_tcp)
            begin
                priority if (tcp_rel[4:0] < 5'd2)
                    upd.src_port = {sport_reg[7:0], byte_data};
                else if (tcp_rel[4:0] < 5'd4)
                    upd.dst_port = {dport_reg[7:0], byte_data};
                else if (tcp_rel[4:0] < 5'd8)
                    upd.seq_num = {seq_reg[23:0], byte_data};
                else if (tcp_rel[4:0] < 5'd12)
                    upd.ack_num = {ack_reg[23:0], byte_data};
                else if (tcp_rel[4:0] < 5'd14)
                    upd.offset_and_flags = {offs_reg[7:0], byte_data};
                else if (tcp_rel[4:0] < 5'd16)
                    upd.window = {win_reg[7:0], byte_data};
                else if (tcp_rel[4:0] < 5'd18)
                    upd.tcp_checksum = {csum_reg[7:0], byte_data};
                else
                    upd.urgent_ptr = {urg_reg[7:0], byte_data};
            end
        end
    end

    assign frame_snap = upd;

    // Frame state clears after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            etype_reg <= '0;
            tlen_reg  <= '0;
            words_reg <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            seq_reg   <= '0;
            ack_reg   <= '0;
            offs_reg  <= '0;
            win_reg   <= '0;
            csum_reg  <= '0;
            urg_reg   <= '0;
        end
        else if (byte_en && byte_last)
        begin
            pos_reg   <= '0;
            etype_reg <= '0;
            tlen_reg  <= '0;
            words_reg <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            seq_reg   <= '0;
            ack_reg   <= '0;
            offs_reg  <= '0;
            win_reg   <= '0;
            csum_reg  <= '0;
            urg_reg   <= '0;
        end
        else if (byte_en)
        begin
            pos_reg   <= upd.size;
            etype_reg <= upd.ether_kind;
            tlen_reg  <= upd.total_len;
            words_reg <= upd.hdr_words;
            proto_reg <= upd.proto;
            src_reg   <= upd.src_addr;
            dst_reg   <= upd.dst_addr;
            sport_reg <= upd.src_port;
            dport_reg <= upd.dst_port;
            seq_reg   <= upd.seq_num;
            ack_reg   <= upd.ack_num;
            offs_reg  <= upd.offset_and_flags;
            win_reg   <= upd.window;
            csum_reg  <= upd.tcp_checksum;
            urg_reg   <= upd.urgent_ptr;
        end
    end

endmodule

FILE: sv/ethtcp_check.sv
// ----------------------------------------------------------------------------
// ethtcp_check
// Header checks in fixed order, status code and payload length of a frame.
// ----------------------------------------------------------------------------
module ethtcp_check
    import ethtcp_pkg::*;
(
    input  frame_t  frame_hdr,
    input  logic    link_is_ethernet,
    output result_t result_data
);

    logic [15:0] avail;
    logic [15:0] ip_hdr;
    logic [15:0] seg;
    logic [15:0] tcp_hdr;
    status_t     status;

    assign avail   = (frame_hdr.size >= ETH_HDR_BYTES) ? (frame_hdr.size - ETH_HDR_BYTES)
                                                       : 16'd0;
    assign ip_hdr  = {10'd0, frame_hdr.hdr_words, 2'b00};
    assign seg     = frame_hdr.total_len - ip_hdr;
    assign tcp_hdr = {10'd0, frame_hdr.offset_and_flags[15:12], 2'b00};

    always_comb
    begin
        priority if (!link_is_ethernet)                   status = ST_NOT_ETHERNET;
        else if (frame_hdr.size < ETH_HDR_BYTES)          status = ST_SHORT_FRAME;
        else if (frame_hdr.ether_kind != ETHERTYPE_IPV4)  status = ST_NOT_IPV4;
        else if (avail < MIN_HDR_BYTES)                   status = ST_SHORT_IP;
        else if (frame_hdr.total_len > avail)             status = ST_TOTLEN_OVER;
        else if (frame_hdr.total_len < MIN_HDR_BYTES)     status = ST_TOTLEN_UNDER;
        else if (ip_hdr < MIN_HDR_BYTES)                  status = ST_IHL_UNDER;
        else if (ip_hdr > frame_hdr.total_len)            status = ST_IHL_OVER;
        else if (frame_hdr.proto != PROTO_TCP)            status = ST_NOT_TCP;
        else if (seg < MIN_HDR_BYTES)                     status = ST_SHORT_SEG;
        else if (tcp_hdr < MIN_HDR_BYTES || tcp_hdr > seg) status = ST_BAD_OFFSET;
        else                                              status = ST_OK;
    end

    // Fields read as zero on any failed check
    always_comb
    begin
        result_data        = '0;
        result_data.status = status;
        if (status == ST_OK)
        begin
            result_data.src_addr         = frame_hdr.src_addr;
            result_data.dst_addr         = frame_hdr.dst_addr;
            result_data.src_port         = frame_hdr.src_port;
            result_data.dst_port         = frame_hdr.dst_port;
            result_data.seq_num          = frame_hdr.seq_num;
            result_data.ack_num          = frame_hdr.ack_num;
            result_data.offset_and_flags = frame_hdr.offset_and_flags;
            result_data.window           = frame_hdr.window;
            result_data.tcp_checksum     = frame_hdr.tcp_checksum;
            result_data.urgent_ptr       = frame_hdr.urgent_ptr;
            result_data.payload_length   = seg - tcp_hdr;
        end
    end

endmodule

FILE: sv/eth_ipv4_tcp_header_parser.sv
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_parser
// Parses Ethernet/IPv4/TCP headers from a byte stream, one result per frame.
// ----------------------------------------------------------------------------
//
//   port      dir   items                    handshake
//   --------  ----  -----------------------  -------------------------------
//   frame     in    one frame byte + last    valid/ready, taken on both high
//   result    out   status + TCP fields      valid/ready, taken on both high
//   cfg_wr_*  in    link_is_ethernet bit     write on cfg_wr_en, no wait
//
// One byte per cycle sustained, save while a last byte waits on the result
// path. A byte passes the input register and updates the frame latches,
// and on the last byte the captured headers move to a snapshot register;
// the checks run between snapshot and result register. Reset clears all
// control and frame state; link_is_ethernet resets to 1. Only a last byte
// waits on a full result path; other bytes never stall.
//
module eth_ipv4_tcp_header_parser
    import ethtcp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 16384
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    ethtcp_frame_if.sink           frame,
    ethtcp_result_if.source        result,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data
);

    // Input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Snapshot of a finished frame's headers
    logic       snap_vld_reg, snap_vld_next;
    frame_t     snap_reg;

    // Result register
    logic       out_vld_reg, out_vld_next;
    result_t    out_reg;

    logic       link_reg;

    frame_t     cap_snap;
    result_t    chk_result;

    logic       out_free;   // result register can load this cycle
    logic       snap_free;  // snapshot register can load this cycle
    logic       in_take;    // input register byte is consumed

    assign out_free  = !out_vld_reg || result.ready;
    assign snap_free = !snap_vld_reg || out_free;
    assign in_take   = in_vld_reg && (!in_last_reg || snap_free);

    assign frame.ready = !in_vld_reg || in_take;

    ethtcp_capture #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_en    (in_take),
        .byte_data  (in_byte_reg),
        .byte_last  (in_last_reg),
        .frame_snap (cap_snap)
    );

    ethtcp_check u_check (
        .frame_hdr        (snap_reg),
        .link_is_ethernet (link_reg),
        .result_data      (chk_result)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (frame.ready)
            in_vld_next = frame.valid;

        snap_vld_next = snap_vld_reg;
        if (in_take && in_last_reg)
            snap_vld_next = 1'b1;
        else if (out_free)
            snap_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (snap_vld_reg && out_free)
            out_vld_next = 1'b1;
        else if (result.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            snap_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            link_reg     <= 1'b1;
        end
        else
        begin
            in_vld_reg   <= in_vld_next;
            snap_vld_reg <= snap_vld_next;
            out_vld_reg  <= out_vld_next;
            if (cfg_wr_en)
                link_reg <= cfg_wr_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            in_byte_reg <= frame.frame_byte;
            in_last_reg <= frame.frame_last;
        end
        if (in_take && in_last_reg)
            snap_reg <= cap_snap;
        if (snap_vld_reg && out_free)
            out_reg <= chk_result;
    end

    assign result.valid            = out_vld_reg;
    assign result.status           = out_reg.status;
    assign result.src_addr         = out_reg.src_addr;
    assign result.dst_addr         = out_reg.dst_addr;
    assign result.src_port         = out_reg.src_port;
    assign result.dst_port         = out_reg.dst_port;
    assign result.seq_num          = out_reg.seq_num;
    assign result.ack_num          = out_reg.ack_num;
    assign result.offset_and_flags = out_reg.offset_and_flags;
    assign result.window           = out_reg.window;
    assign result.tcp_checksum     = out_reg.tcp_checksum;
    assign result.urgent_ptr       = out_reg.urgent_ptr;
    assign result.payload_length   = out_reg.payload_length;

endmodule

FILE: sv/ethtcp_checker.sv
// ----------------------------------------------------------------------------
// ethtcp_checker
// Port-level assertions for the header parser, bound to the top level.
// ----------------------------------------------------------------------------
module ethtcp_checker
    import ethtcp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [3:0]  result_status,
    input logic [31:0] result_src_addr,
    input logic [31:0] result_seq_num,
    input logic [15:0] result_offset_and_flags,
    input logic [15:0] result_payload_length
);

    // Stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_status)
            && $stable(result_payload_length))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_status <= ST_BAD_OFFSET)
        else $error("status code out of range");

    // Failed check blanks the fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_status != ST_OK |-> result_src_addr == 32'd0
            && result_seq_num == 32'd0 && result_offset_and_flags == 16'd0
            && result_payload_length == 16'd0)
        else $error("fields not cleared on failed frame");

    // Good frame has a TCP data offset of at least five words
    a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_status == ST_OK |-> result_offset_and_flags[15:12] >= 4'd5)
        else $error("accepted frame with short TCP header");

endmodule

bind eth_ipv4_tcp_header_parser ethtcp_checker u_ethtcp_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .result_valid            (result.valid),
    .result_ready            (result.ready),
    .result_status           (result.status),
    .result_src_addr         (result.src_addr),
    .result_seq_num          (result.seq_num),
    .result_offset_and_flags (result.offset_and_flags),
    .result_payload_length   (result.payload_length)
);

FILE: dv/tb_eth_ipv4_tcp_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eth_ipv4_tcp_header_parser
// Self-checking bench: frames go in byte by byte, and every result is checked
// field by field against a bench-side header decoder. A table of directed
// frames covers each status code and the field extremes. Random well-formed
// and broken frames follow, with both link settings, random idling on both
// channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_eth_ipv4_tcp_header_parser;
    import ethtcp_pkg::*;

    localparam int MAX_FRAME_BYTES = 16384;
    localparam int SETTLE_CYCLES   = 12;       // pipeline depth plus margin
    localparam int HOLD_CYCLES     = 300;      // long result back-pressure
    localparam int RANDOM_BYTES    = 350;
    localparam int N_DIRECTED      = 22;

    typedef logic [7:0] byte_q_t[$];

    // how the bytes outside the header fields of a frame are filled
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    // one frame: header fields placed at their offsets, rest filled
    typedef struct {
        bit          link;       // link_is_ethernet setting for this frame
        int unsigned len;        // bytes on the wire
        fill_t       fill;
        logic [15:0] ether;
        logic [7:0]  vihl;       // version / IHL byte
        logic [15:0] total_len;
        logic [7:0]  proto;
        logic [7:0]  offs;       // TCP data offset byte
        bit          known;      // status typed in below, fields all zero
        status_t     status;
    } frame_row_t;

    typedef struct {
        bit      known;
        status_t status;
    } frame_note_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    ethtcp_frame_if  frame_ch();
    ethtcp_result_if result_ch();

    eth_ipv4_tcp_header_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // Directed frames. Rows with a typed status expect all other fields zero;
    // the rest are checked against the decoder.
    // ------------------------------------------------------------------------
    frame_row_t directed_rows [N_DIRECTED] = '{
        // first frame after reset: a single byte
        '{1'b1, 1,   FILL_RANDOM, 16'h0800, 8'h45, 16'd40,   8'd6,  8'h50, 1'b1,
          ST_SHORT_FRAME},
        '{1'b1, 13,  FILL_RANDOM, 16'h0800, 8'h45, 16'd40,   8'd6,  8'h50, 1'b1,
          ST_SHORT_FRAME},
        // Ethernet header only, nothing after it
        '{1'b1, 14,  FILL_RANDOM, 16'h0800, 8'h45, 16'd40,   8'd6,  8'h50, 1'b1,
          ST_SHORT_IP},
        '{1'b1, 33,  FILL_RANDOM, 16'h0800, 8'h45, 16'd19,   8'd6,  8'h50, 1'b1,
          ST_SHORT_IP},
        '{1'b1, 14,  FILL_RANDOM, 16'h86DD, 8'h45, 16'd40,   8'd6,  8'h50, 1'b1,
          ST_NOT_IPV4},
        '{1'b1, 14,  FILL_ZERO,   16'h0000, 8'h00, 16'd0,    8'd0,  8'h00, 1'b1,
          ST_NOT_IPV4},
        '{1'b1, 14,  FILL_ONES,   16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1,
          ST_NOT_IPV4},
        // total length one past what arrived
        '{1'b1, 34,  FILL_RANDOM, 16'h0800, 8'h45, 16'd21,   8'd6,  8'h50, 1'b1,
          ST_TOTLEN_OVER},
        '{1'b1, 34,  FILL_RANDOM, 16'h0800, 8'h45, 16'hFFFF, 8'd6,  8'h50, 1'b1,
          ST_TOTLEN_OVER},
        '{1'b1, 34,  FILL_RANDOM, 16'h0800, 8'h45, 16'd19,   8'd6,  8'h50, 1'b1,
          ST_TOTLEN_UNDER},
        // short IHL: TCP ports land in the IP header, still rejected
        '{1'b1, 34,  FILL_RANDOM, 16'h0800, 8'h44, 16'd20,   8'd6,  8'h50, 1'b1,
          ST_IHL_UNDER},
        '{1'b1, 34,  FILL_RANDOM, 16'h0800, 8'h40, 16'd20,   8'd6,  8'h50, 1'b1,
          ST_IHL_UNDER},
        '{1'b1, 34,  FILL_RANDOM, 16'h0800, 8'h4F, 16'd20,   8'd6,  8'h50, 1'b1,
          ST_IHL_OVER},
        '{1'b1, 34,  FILL_RANDOM, 16'h0800, 8'h45, 16'd20,   8'd17, 8'h50, 1'b1,
          ST_NOT_TCP},
        '{1'b1, 53,  FILL_RANDOM, 16'h0800, 8'h45, 16'd39,   8'd6,  8'h50, 1'b1,
          ST_SHORT_SEG},
        '{1'b1, 54,  FILL_RANDOM, 16'h0800, 8'h45, 16'd40,   8'd6,  8'h40, 1'b1,
          ST_BAD_OFFSET},
        '{1'b1, 54,  FILL_RANDOM, 16'h0800, 8'h45, 16'd40,   8'd6,  8'hF0, 1'b1,
          ST_BAD_OFFSET},
        // largest IP and TCP headers
        '{1'b1, 134, FILL_RANDOM, 16'h0800, 8'h4F, 16'd120,  8'd6,  8'hFF, 1'b0,
          ST_OK},
        // smallest good frame; version nibble is not checked; all-zero and
        // all-one field values
        '{1'b1, 54,  FILL_ZERO,   16'h0800, 8'h05, 16'd40,   8'd6,  8'h50, 1'b0,
          ST_OK},
        '{1'b1, 60,  FILL_ONES,   16'h0800, 8'hF5, 16'd46,   8'd6,  8'h5F, 1'b0,
          ST_OK},
        // link type not Ethernet rejects everything
        '{1'b0, 14,  FILL_RANDOM, 16'h0800, 8'h45, 16'd40,   8'd6,  8'h50, 1'b1,
          ST_NOT_ETHERNET},
        '{1'b0, 1,   FILL_RANDOM, 16'h0800, 8'h45, 16'd40,   8'd6,  8'h50, 1'b1,
          ST_NOT_ETHERNET}
    };

    // ------------------------------------------------------------------------
    // Header decoder: mirrors the block's per-frame latches
    // ------------------------------------------------------------------------
    logic        link_cfg = 1'b1;              // reset value of the register
    frame_t      hdr_latch = '0;
    result_t     pending_results[$];           // decoded results not yet seen
    frame_note_t frame_notes[$];               // one per frame being sent
    int unsigned fail_count = 0;

    // bench knobs
    bit   idle_mode = 1'b1;                    // random idling on both sides
    logic hold_trigger;                        // toggle starts a long hold

    // Apply one accepted byte; on the last byte decode the frame and queue
    // what the block should return.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        int unsigned pos, tcp_start, r, size, avail, hdr, seg, tcp_hdr;
        status_t     st;
        result_t     want;
        frame_note_t note;
        seg = 0;
        tcp_hdr = 0;
        if (hdr_latch.size < MAX_FRAME_BYTES) begin
            pos = hdr_latch.size;
            if (pos == 12 || pos == 13)
                hdr_latch.ether_kind = {hdr_latch.ether_kind[7:0], b};
            if (pos == 14)
                hdr_latch.hdr_words = b[3:0];
            if (pos == 16 || pos == 17)
                hdr_latch.total_len = {hdr_latch.total_len[7:0], b};
            if (pos == 23)
                hdr_latch.proto = b;
            if (pos >= 26 && pos <= 29)
                hdr_latch.src_addr = {hdr_latch.src_addr[23:0], b};
            if (pos >= 30 && pos <= 33)
                hdr_latch.dst_addr = {hdr_latch.dst_addr[23:0], b};
            // TCP header position follows the IHL latched at byte 14
            if (pos > 14) begin
                tcp_start = 14 + hdr_latch.hdr_words * 4;
                if (pos >= tcp_start && pos < tcp_start + 20) begin
                    r = pos - tcp_start;
                    if (r < 2)
                        hdr_latch.src_port = {hdr_latch.src_port[7:0], b};
                    else if (r < 4)
                        hdr_latch.dst_port = {hdr_latch.dst_port[7:0], b};
                    else if (r < 8)
                        hdr_latch.seq_num = {hdr_latch.seq_num[23:0], b};
                    else if (r < 12)
                        hdr_latch.ack_num = {hdr_latch.ack_num[23:0], b};
                    else if (r < 14)
                        hdr_latch.offset_and_flags = {hdr_latch.offset_and_flags[7:0], b};
                    else if (r < 16)
                        hdr_latch.window = {hdr_latch.window[7:0], b};
                    else if (r < 18)
                        hdr_latch.tcp_checksum = {hdr_latch.tcp_checksum[7:0], b};
                    else
                        hdr_latch.urgent_ptr = {hdr_latch.urgent_ptr[7:0], b};
                end
            end
            hdr_latch.size = hdr_latch.size + 1'b1;
        end
        if (last) begin
            size  = hdr_latch.size;
            avail = (size >= ETH_HDR_BYTES) ? size - ETH_HDR_BYTES : 0;
            hdr   = hdr_latch.hdr_words * 4;
            // checks in the block's fixed order
            if (!link_cfg)                               st = ST_NOT_ETHERNET;
            else if (size < ETH_HDR_BYTES)               st = ST_SHORT_FRAME;
            else if (hdr_latch.ether_kind != ETHERTYPE_IPV4) st = ST_NOT_IPV4;
            else if (avail < MIN_HDR_BYTES)              st = ST_SHORT_IP;
            else if (hdr_latch.total_len > avail)        st = ST_TOTLEN_OVER;
            else if (hdr_latch.total_len < MIN_HDR_BYTES) st = ST_TOTLEN_UNDER;
            else if (hdr < MIN_HDR_BYTES)                st = ST_IHL_UNDER;
            else if (hdr > hdr_latch.total_len)          st = ST_IHL_OVER;
            else if (hdr_latch.proto != PROTO_TCP)       st = ST_NOT_TCP;
            else begin
                seg     = hdr_latch.total_len - hdr;
                tcp_hdr = hdr_latch.offset_and_flags[15:12] * 4;
                if (seg < MIN_HDR_BYTES)                        st = ST_SHORT_SEG;
                else if (tcp_hdr < MIN_HDR_BYTES || tcp_hdr > seg) st = ST_BAD_OFFSET;
                else                                            st = ST_OK;
            end
            want = '0;
            want.status = st;
            if (st == ST_OK) begin
                want.src_addr         = hdr_latch.src_addr;
                want.dst_addr         = hdr_latch.dst_addr;
                want.src_port         = hdr_latch.src_port;
                want.dst_port         = hdr_latch.dst_port;
                want.seq_num          = hdr_latch.seq_num;
                want.ack_num          = hdr_latch.ack_num;
                want.offset_and_flags = hdr_latch.offset_and_flags;
                want.window           = hdr_latch.window;
                want.tcp_checksum     = hdr_latch.tcp_checksum;
                want.urgent_ptr       = hdr_latch.urgent_ptr;
                want.payload_length   = 16'(seg - tcp_hdr);
            end
            // directed rows with a typed status override the decoder
            if (frame_notes.size() != 0) begin
                note = frame_notes.pop_front();
                if (note.known) begin
                    want = '0;
                    want.status = note.status;
                end
            end
            pending_results.push_back(want);
            hdr_latch = '0;
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: both channels sampled at the edge, before the edge's updates
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        result_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected, status %0d", result_ch.status);
                fail_count++;
            end
            else begin
                want = pending_results.pop_front();
                check_field("status",           want.status,           result_ch.status);
                check_field("src_addr",         want.src_addr,         result_ch.src_addr);
                check_field("dst_addr",         want.dst_addr,         result_ch.dst_addr);
                check_field("src_port",         want.src_port,         result_ch.src_port);
                check_field("dst_port",         want.dst_port,         result_ch.dst_port);
                check_field("seq_num",          want.seq_num,          result_ch.seq_num);
                check_field("ack_num",          want.ack_num,          result_ch.ack_num);
                check_field("offset_and_flags", want.offset_and_flags,
                            result_ch.offset_and_flags);
                check_field("window",           want.window,           result_ch.window);
                check_field("tcp_checksum",     want.tcp_checksum,     result_ch.tcp_checksum);
                check_field("urgent_ptr",       want.urgent_ptr,       result_ch.urgent_ptr);
                check_field("payload_length",   want.payload_length,
                            result_ch.payload_length);
            end
        end
        if (rst_n && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1)
            decode_byte(frame_ch.frame_byte, frame_ch.frame_last);
    end

    // ------------------------------------------------------------------------
    // Result sink: random stall bursts, plus one long hold on request. The
    // hold is counted here so the sender keeps pushing frames meanwhile.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int   stall_left;
        int   hold_left;
        logic seen_trigger;
        result_ch.ready <= 1'b0;
        stall_left = 0;
        hold_left  = 0;
        while (rst_n !== 1'b1) @(posedge clk);
        seen_trigger = hold_trigger;
        forever begin
            @(posedge clk);
            if (hold_trigger !== seen_trigger) begin
                seen_trigger = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (idle_mode && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                result_ch.ready <= 1'b0;
            end
            else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Frame builder and sender
    // ------------------------------------------------------------------------
    function automatic byte_q_t build_frame(frame_row_t row);
        byte_q_t     q;
        int unsigned tcp_start, n;
        tcp_start = 14 + row.vihl[3:0] * 4;
        n = (row.len > 96) ? row.len : 96;     // room for every header offset
        for (int i = 0; i < n; i++) begin
            case (row.fill)
                FILL_ZERO: q.push_back(8'h00);
                FILL_ONES: q.push_back(8'hFF);
                default:   q.push_back(8'($urandom));
            endcase
        end
        // TCP offset first: with a short IHL it may sit under IP fields
        q[tcp_start + 12] = row.offs;
        q[12] = row.ether[15:8];
        q[13] = row.ether[7:0];
        q[14] = row.vihl;
        q[16] = row.total_len[15:8];
        q[17] = row.total_len[7:0];
        q[23] = row.proto;
        while (q.size() > row.len) void'(q.pop_back());
        return q;
    endfunction

    // Random frame: mostly well-formed with random content, the rest with
    // one header field broken or cut short.
    function automatic frame_row_t random_row();
        frame_row_t  row;
        int unsigned ihl, off, pay, pad;
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        off = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        pay = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        row.link      = 1'b1;
        row.fill      = FILL_RANDOM;
        row.ether     = ETHERTYPE_IPV4;
        row.vihl      = {(($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4), 4'(ihl)};
        row.total_len = 16'(ihl * 4 + off * 4 + pay);
        row.proto     = PROTO_TCP;
        row.offs      = {4'(off), 4'($urandom)};
        row.len       = 14 + row.total_len + pad;
        row.known     = 1'b0;
        row.status    = ST_OK;
        if ($urandom_range(0, 9) >= 7) begin
            case ($urandom_range(0, 6))
                0: row.len       = $urandom_range(1, 60);
                1: row.ether     = 16'($urandom);
                2: row.proto     = 8'($urandom);
                3: row.total_len = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                 : 16'($urandom_range(0, row.len));
                4: row.vihl      = 8'($urandom);
                5: row.offs      = 8'($urandom);
                default: row.len = row.len - $urandom_range(1, 5);
            endcase
        end
        return row;
    endfunction

    // Offer one byte and hold it until taken; maybe idle afterwards
    task automatic send_byte(input logic [7:0] b, input logic last);
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_byte <= b;
        frame_ch.frame_last <= last;
        @(posedge clk);
        while (frame_ch.ready !== 1'b1) @(posedge clk);
        if (idle_mode && $urandom_range(0, 15) == 0) begin
            frame_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every result is back and the pipe is empty
    task automatic wait_idle();
        frame_ch.valid <= 1'b0;
        while (pending_results.size() != 0 || frame_notes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_link(input logic value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        link_cfg = value;
    endtask

    task automatic run_frame(input frame_row_t row);
        byte_q_t     q;
        frame_note_t note;
        if (row.link != link_cfg)
            write_link(row.link);
        q = build_frame(row);
        note.known  = row.known;
        note.status = row.status;
        frame_notes.push_back(note);
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        frame_row_t  row;
        int unsigned random_bytes;
        frame_ch.valid      <= 1'b0;
        frame_ch.frame_byte <= 8'h00;
        frame_ch.frame_last <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= 1'b0;
        hold_trigger        <= 1'b0;
        random_bytes = 0;
        while (rst_n !== 1'b1) @(posedge clk);
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
            run_frame(directed_rows[i]);

        // random frames, Ethernet link, idling comes and goes per frame
        for (int i = 0; i < 3; i++) begin
            idle_mode = ($urandom_range(0, 3) != 0);
            row = random_row();
            random_bytes += row.len;
            run_frame(row);
        end
        idle_mode = 1'b1;

        // non-Ethernet link
        for (int i = 0; i < 2; i++) begin
            row = random_row();
            row.link = 1'b0;
            random_bytes += row.len;
            run_frame(row);
        end

        // long result hold while short frames keep coming, so the result
        // path fills and the input stalls on a last byte
        write_link(1'b1);
        hold_trigger <= ~hold_trigger;
        for (int i = 0; i < 6; i++) begin
            row = random_row();
            row.len = $urandom_range(1, 20);
            random_bytes += row.len;
            run_frame(row);
        end

        // last stretch with no idling on either side
        idle_mode = 1'b0;
        for (int i = 0; i < 2 || random_bytes < RANDOM_BYTES; i++) begin
            row = random_row();
            random_bytes += row.len;
            run_frame(row);
        end

        wait_idle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
